// File: sv/pmm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pmm_pkg
// Types, pattern constants and the window compare function shared by the
// path multi-pattern matcher.
// ============================================================================
package pmm_pkg;

    localparam int WIN_LEN  = 28;
    localparam int TABLE_N  = 11;
    localparam int IDX_W    = 4;
    localparam int LEN_W    = 5;
    localparam int PAT_W    = 8 * WIN_LEN;

    localparam logic [7:0] FOLD_MASK = 8'h20;
    localparam logic [7:0] DOT_CHAR  = 8'h2E;

    // Index of the only warning-class table entry
    localparam logic [IDX_W-1:0] IDX_MPR = 4'd7;

    typedef logic [WIN_LEN-1:0][7:0] t_win;
    typedef logic [PAT_W-1:0]        t_pat;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic             amsi_hit;
        logic             automation_hit;
        logic             table_hit;
        logic [IDX_W-1:0] table_index;
        logic             table_critical;
        logic             ntdll_suffix;
    } t_result;

    // Pattern hits ending at the newest window byte
    typedef struct packed {
        logic               amsi;
        logic               automation;
        logic               ntdll;
        logic [TABLE_N-1:0] tbl;
    } t_hits;

    // Patterns: last character sits in the low byte
    localparam t_pat AMSI_PAT  = t_pat'("amsi.dll");
    localparam t_pat AUTO_PAT  = t_pat'("system.management.automation");
    localparam t_pat NTDLL_PAT = t_pat'("ntdll.dll");

    localparam logic [LEN_W-1:0] AMSI_LEN  = 5'd8;
    localparam logic [LEN_W-1:0] AUTO_LEN  = 5'd28;
    localparam logic [LEN_W-1:0] NTDLL_LEN = 5'd9;

    localparam t_pat TABLE_PAT [TABLE_N] = '{
        t_pat'("samlib.dll"),
        t_pat'("cryptdll.dll"),
        t_pat'("msasn1.dll"),
        t_pat'("winscard.dll"),
        t_pat'("rstrtmgr.dll"),
        t_pat'("fltlib.dll"),
        t_pat'("winsta.dll"),
        t_pat'("mpr.dll"),
        t_pat'("dbghelp.dll"),
        t_pat'("secur32.dll"),
        t_pat'("netapi32.dll")
    };

    localparam logic [LEN_W-1:0] TABLE_LEN [TABLE_N] = '{
        5'd10, 5'd12, 5'd10, 5'd12, 5'd12, 5'd10, 5'd10, 5'd7, 5'd11, 5'd11, 5'd12
    };

    // One bit per entry, 1 = critical; mpr.dll is the warning entry
    localparam logic [TABLE_N-1:0] TABLE_CRIT = 11'b111_0111_1111;

    // True when the window ends with the pattern; exact_dot compares dots unfolded
    function automatic logic ends_with(t_win w, t_pat pat, logic [LEN_W-1:0] len,
                                       logic exact_dot);
        logic       ok;
        logic [7:0] c;
        logic [7:0] p;
        ok = 1'b1;
        for (int j = 0; j < WIN_LEN; j++) begin
            c = w[WIN_LEN-1-j];
            p = pat[8*j +: 8];
            if (LEN_W'(j) < len) begin
                if (exact_dot && (p == DOT_CHAR)) begin
                    if (c != p) ok = 1'b0;
                end else if ((c | FOLD_MASK) != p) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

endpackage

// File: sv/pmm_match.sv
`timescale 1ns / 1ps
// ============================================================================
// pmm_match
// Parallel comparators of the byte window against every fixed pattern.
// ============================================================================
module pmm_match
    import pmm_pkg::*;
(
    input  t_win  i_win,
    output t_hits o_hits
);

    // Compare all patterns against the window tail
    always_comb begin
        o_hits.amsi       = ends_with(i_win, AMSI_PAT, AMSI_LEN, 1'b1);
        o_hits.automation = ends_with(i_win, AUTO_PAT, AUTO_LEN, 1'b1);
        o_hits.ntdll      = ends_with(i_win, NTDLL_PAT, NTDLL_LEN, 1'b0);
        for (int k = 0; k < TABLE_N; k++) begin
            o_hits.tbl[k] = ends_with(i_win, TABLE_PAT[k], TABLE_LEN[k], 1'b0);
        end
    end

endmodule

// File: sv/path_multi_pattern_matcher_core.sv
`timescale 1ns / 1ps
// ============================================================================
// path_multi_pattern_matcher_core
// Byte-stream path scanner with sticky pattern flags and a DLL name table.
// ============================================================================
// The block takes one path byte per cycle and keeps doing so without gaps as
// long as the result side is not stalled. Each byte lands in an input
// register; in the next cycle it is shifted into a 28-byte window whose tail
// is compared against all fixed patterns in parallel, and the sticky flags
// are updated. On the byte marked last the result is written to the output
// register as that byte leaves the input register, and the window and flags
// are cleared for the next path. Only a last byte waits, and only while an
// earlier result is still held in the output register.
module path_multi_pattern_matcher_core
    import pmm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_item   i_in_item,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_item
);

    logic               r_in_valid;
    t_item              r_in;
    t_win               r_win;
    logic               r_amsi;
    logic               r_auto;
    logic [TABLE_N-1:0] r_mask;
    logic               r_out_valid;
    t_result            r_out;

    logic               w_advance;
    t_win               w_win;
    t_hits              w_hits;
    logic               n_amsi;
    logic               n_auto;
    logic [TABLE_N-1:0] n_mask;
    t_result            n_out;

    // Move the held item on unless it is a last byte facing a full output
    assign w_advance  = r_in_valid && (!r_in.last_byte || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    // Shift the new byte into the newest window slot
    assign w_win = {r_in.path_byte, r_win[WIN_LEN-1:1]};

    pmm_match u_match (
        .i_win  (w_win),
        .o_hits (w_hits)
    );

    // Merge this byte's hits into the sticky flags and build the result
    always_comb begin
        n_amsi = r_amsi | w_hits.amsi;
        n_auto = r_auto | w_hits.automation;
        n_mask = r_mask | w_hits.tbl;

        n_out                = '0;
        n_out.amsi_hit       = n_amsi;
        n_out.automation_hit = n_auto;
        n_out.ntdll_suffix   = w_hits.ntdll;
        // Lowest set index wins
        for (int k = TABLE_N - 1; k >= 0; k--) begin
            if (n_mask[k]) begin
                n_out.table_hit      = 1'b1;
                n_out.table_index    = IDX_W'(k);
                n_out.table_critical = TABLE_CRIT[k];
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Window and sticky flags; clear after the last byte of a path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_amsi <= 1'b0;
            r_auto <= 1'b0;
            r_mask <= '0;
        end else if (w_advance) begin
            if (r_in.last_byte) begin
                r_win  <= '0;
                r_amsi <= 1'b0;
                r_auto <= 1'b0;
                r_mask <= '0;
            end else begin
                r_win  <= w_win;
                r_amsi <= n_amsi;
                r_auto <= n_auto;
                r_mask <= n_mask;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in.last_byte) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // A byte that is not last never raises a result
    a_no_result_mid_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !r_in.last_byte && !r_out_valid) |=> !r_out_valid)
        else $error("result raised by a byte that is not last");

    // End of path leaves a clean window and clear flags
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.last_byte) |=>
            (r_win == '0 && r_mask == '0 && !r_amsi && !r_auto))
        else $error("state not cleared after last byte");

    // No table hit means zero index and warning class
    a_no_hit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.table_hit) |->
            (o_out_item.table_index == '0 && !o_out_item.table_critical))
        else $error("table fields set without a table hit");

    // Only the mpr.dll entry reports warning class
    a_warning_is_mpr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.table_hit && !o_out_item.table_critical) |->
            (o_out_item.table_index == IDX_MPR))
        else $error("warning class on an entry other than mpr.dll");

endmodule
